### rtl/line_pixel_interpolator_assert.svh
// ---------------------------------------------------------------------------
// Line pixel interpolator assertion macros
// Shared property macros for the checker of the line pixel interpolator.
// ---------------------------------------------------------------------------
`ifndef LINE_PIXEL_INTERPOLATOR_ASSERT_SVH
`define LINE_PIXEL_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lpi_pkg.sv
// ---------------------------------------------------------------------------
// Line pixel interpolator package
// Word types, widths and fixed constants shared by the interpolator files.
// ---------------------------------------------------------------------------
package lpi_pkg;

    localparam int COORD_W     = 6;
    localparam int ADDR_W      = 12;
    localparam int COLOR_W     = 24;
    localparam int WIDTH_W     = 7;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int COORD_RANGE = 64;

    // one quotient bit per divider step; quotients never exceed the coordinate range
    localparam int DIV_STEPS   = COORD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [WIDTH_W-1:0] CANVAS_WIDTH_RESET = 7'd64;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [WIDTH_W-1:0] t_width;
    typedef logic [PROD_W-1:0]  t_prod;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        t_color pen_color;
    } t_line_cmd;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_addr  pixel_address;
        t_color pixel_color;
        logic   last_pixel;
    } t_pixel_word;

    typedef struct packed {
        logic   start;
        t_prod  numer;
        t_coord denom;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_coord quot;
    } t_div_rsp;

    function automatic t_coord coord_wrap(input t_coord v);
        coord_wrap = t_coord'(v % COORD_RANGE);
    endfunction

endpackage

### rtl/line_pixel_interpolator.sv
// ---------------------------------------------------------------------------
// Line pixel interpolator
// Turns one line command into a run of pixel write words from end to start.
// ---------------------------------------------------------------------------
// A command word is taken at a rising edge with start high and busy low. The
// block then emits n = max(|dx|, |dy|) + 1 pixel words, from (end_x, end_y) to
// (start_x, start_y), each shown for exactly one cycle with o_pixel_strobe
// high; the receiver cannot stall, so capture every strobed word. The first
// pixel, the end point itself, passes only through the address multiply and
// the output register. Every later pixel first forms its four quotients
// (start and end of x and y, each times the step index over n-1) one after
// another on a single six-step serial divider (form the product, load the
// divider, six steps, collect the quotient), then the address multiply and
// the output register. busy stays high while the line runs, up to 64 pixels,
// and drops in the cycle that shows the last pixel, so the next
// command may be offered then. canvas_width is written through the cfg
// channel, which is always ready; write it only while busy is low.
// ---------------------------------------------------------------------------
module line_pixel_interpolator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lpi_pkg::t_line_cmd   i_cmd,
    output logic                 o_pixel_strobe,
    output lpi_pkg::t_pixel_word o_pixel,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  lpi_pkg::t_width      i_cfg_data
);
    import lpi_pkg::*;

    // sequencer codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL     = 3'd1;
    localparam logic [2:0] S_DIVGO   = 3'd2;
    localparam logic [2:0] S_DIVWAIT = 3'd3;
    localparam logic [2:0] S_ADDR    = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;

    // term codes: which endpoint coordinate is being scaled
    localparam logic [1:0] T_SX = 2'd0;
    localparam logic [1:0] T_EX = 2'd1;
    localparam logic [1:0] T_SY = 2'd2;
    localparam logic [1:0] T_EY = 2'd3;

    logic [2:0]  r_state, n_state;
    t_width      r_width, n_width;
    logic        r_strobe, n_strobe;
    t_pixel_word r_out, n_out;

    t_coord       r_sx, n_sx;
    t_coord       r_sy, n_sy;
    t_coord       r_ex, n_ex;
    t_coord       r_ey, n_ey;
    t_color       r_color, n_color;
    t_coord       r_denom, n_denom;
    t_coord       r_step, n_step;
    logic [1:0]   r_term, n_term;
    t_prod        r_prod, n_prod;
    logic [COORD_W:0] r_acc, n_acc;
    t_coord       r_px, n_px;
    t_coord       r_py, n_py;
    t_addr        r_aprod, n_aprod;

    t_coord                   cmd_sx, cmd_sy, cmd_ex, cmd_ey;
    t_coord                   span_x, span_y;
    t_coord                   operand;
    t_prod                    mul_full;
    logic [COORD_W+WIDTH_W-1:0] addr_full;
    logic                     accept;
    logic                     is_last;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    assign accept = start && (r_state == S_IDLE);

    // wrap the incoming coordinates to the canvas range
    assign cmd_sx = coord_wrap(i_cmd.start_x);
    assign cmd_sy = coord_wrap(i_cmd.start_y);
    assign cmd_ex = coord_wrap(i_cmd.end_x);
    assign cmd_ey = coord_wrap(i_cmd.end_y);
    assign span_x = (cmd_sx >= cmd_ex) ? (cmd_sx - cmd_ex) : (cmd_ex - cmd_sx);
    assign span_y = (cmd_sy >= cmd_ey) ? (cmd_sy - cmd_ey) : (cmd_ey - cmd_sy);

    always_comb begin
        case (r_term)
            T_SX:    operand = r_sx;
            T_EX:    operand = r_ex;
            T_SY:    operand = r_sy;
            T_EY:    operand = r_ey;
            default: operand = r_sx;
        endcase
    end

    // the one product per state: coordinate times step, or row times width
    assign mul_full  = {{COORD_W{1'b0}}, operand} * {{COORD_W{1'b0}}, r_step};
    assign addr_full = {{WIDTH_W{1'b0}}, r_py} * {{COORD_W{1'b0}}, r_width};
    assign is_last   = (r_step == r_denom);

    assign div_req.start = (r_state == S_DIVGO);
    assign div_req.numer = r_prod;
    assign div_req.denom = r_denom;

    lpi_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state  = r_state;
        n_width  = r_width;
        n_strobe = 1'b0;
        n_out    = r_out;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_ex     = r_ex;
        n_ey     = r_ey;
        n_color  = r_color;
        n_denom  = r_denom;
        n_step   = r_step;
        n_term   = r_term;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_px     = r_px;
        n_py     = r_py;
        n_aprod  = r_aprod;

        if (i_cfg_valid && o_cfg_ready) begin
            n_width = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // latch the command; the first pixel is the end point itself,
                    // which also covers equal endpoints without any division
                    n_sx    = cmd_sx;
                    n_sy    = cmd_sy;
                    n_ex    = cmd_ex;
                    n_ey    = cmd_ey;
                    n_color = i_cmd.pen_color;
                    n_denom = (span_x > span_y) ? span_x : span_y;
                    n_step  = '0;
                    n_px    = cmd_ex;
                    n_py    = cmd_ey;
                    n_state = S_ADDR;
                end
            end
            S_MUL: begin
                n_prod  = mul_full;
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                n_state = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (div_rsp.done) begin
                    // coord = start*i/d + end - end*i/d, built up term by term
                    case (r_term)
                        T_SX:    n_acc = {1'b0, div_rsp.quot} + {1'b0, r_ex};
                        T_EX:    n_px  = t_coord'(r_acc - {1'b0, div_rsp.quot});
                        T_SY:    n_acc = {1'b0, div_rsp.quot} + {1'b0, r_ey};
                        T_EY:    n_py  = t_coord'(r_acc - {1'b0, div_rsp.quot});
                        default: n_acc = r_acc;
                    endcase
                    n_term  = r_term + 2'd1;
                    n_state = (r_term == T_EY) ? S_ADDR : S_MUL;
                end
            end
            S_ADDR: begin
                n_aprod = addr_full[ADDR_W-1:0];
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_out.pixel_x       = r_px;
                n_out.pixel_y       = r_py;
                n_out.pixel_address = r_aprod + {{(ADDR_W-COORD_W){1'b0}}, r_px};
                n_out.pixel_color   = r_color;
                n_out.last_pixel    = is_last;
                n_strobe            = 1'b1;
                if (is_last) begin
                    n_state = S_IDLE;
                end else begin
                    // advance to the next step and restart the term sequence
                    n_step  = r_step + t_coord'(1);
                    n_term  = T_SX;
                    n_state = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= CANVAS_WIDTH_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_width  <= n_width;
            r_strobe <= n_strobe;
        end
        r_out   <= n_out;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_ex    <= n_ex;
        r_ey    <= n_ey;
        r_color <= n_color;
        r_denom <= n_denom;
        r_step  <= n_step;
        r_term  <= n_term;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_px    <= n_px;
        r_py    <= n_py;
        r_aprod <= n_aprod;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_pixel_strobe = r_strobe;
    assign o_pixel        = r_out;
    assign o_cfg_ready    = 1'b1;

endmodule

### rtl/lpi_divider.sv
// ---------------------------------------------------------------------------
// Line pixel interpolator divider
// Restoring divider, one quotient bit per cycle, quotient known below 64.
// ---------------------------------------------------------------------------
module lpi_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpi_pkg::t_div_req i_req,
    output lpi_pkg::t_div_rsp o_rsp
);
    import lpi_pkg::*;

    t_coord               r_rem,  n_rem;
    t_coord               r_low,  n_low;
    t_coord               r_den,  n_den;
    t_coord               r_quot, n_quot;
    logic [DIV_CNT_W-1:0] r_cnt,  n_cnt;
    logic                 r_run,  n_run;
    logic                 r_done, n_done;

    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    logic             fits;

    assign trial = {r_rem, r_low[COORD_W-1]};
    assign fits  = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_comb begin
        n_rem  = r_rem;
        n_low  = r_low;
        n_den  = r_den;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_req.start) begin
            // numerator is at most 63 times the divisor, so its top half is below it
            n_rem  = i_req.numer[PROD_W-1:COORD_W];
            n_low  = i_req.numer[COORD_W-1:0];
            n_den  = i_req.denom;
            n_quot = '0;
            n_cnt  = DIV_CNT_W'(DIV_STEPS);
            n_run  = 1'b1;
        end else if (r_run) begin
            n_rem  = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            n_quot = {r_quot[COORD_W-2:0], fits};
            n_low  = {r_low[COORD_W-2:0], 1'b0};
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### rtl/lpi_checker.sv
// ---------------------------------------------------------------------------
// Line pixel interpolator checker
// Port-level timing checks of the interpolator, bound to the top level.
// ---------------------------------------------------------------------------
`include "line_pixel_interpolator_assert.svh"

module lpi_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_pixel_strobe,
    input lpi_pkg::t_pixel_word o_pixel
);
    import lpi_pkg::*;

    logic mid_word;
    logic last_word;

    assign mid_word  = o_pixel_strobe && !o_pixel.last_pixel;
    assign last_word = o_pixel_strobe && o_pixel.last_pixel;

    // an accepted command always keeps the block occupied on the next cycle
    `LPI_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")

    // a pixel word only follows a busy cycle
    `LPI_ASSERT_NOW(a_strobe_after_busy, i_clk, i_rst_n, o_pixel_strobe, $past(busy), "stray word")

    // the line is still running while a non-final word is shown
    `LPI_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, mid_word, busy, "idle mid-line")

    // the final word releases the block
    `LPI_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, last_word, !busy, "busy after last word")

    // pixel words are never on consecutive cycles
    `LPI_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_pixel_strobe, !o_pixel_strobe, "word gap")

endmodule

bind line_pixel_interpolator lpi_checker u_lpi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_pixel_strobe (o_pixel_strobe),
    .o_pixel        (o_pixel)
);
